// ===== rtl/core/c2p_pkg.sv =====
// Package with the register indexes, field widths and result type of the chunky-to-planar writer.
package c2p_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned PIXEL_W  = 8;
    localparam int unsigned OFFSET_W = 28;
    localparam int unsigned BYTES_W  = 64;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned EN_W     = 8;
    localparam int unsigned COORD_W  = 15;
    localparam int unsigned BPR_W    = 12;
    localparam int unsigned DEPTH_W  = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned M_TDATA_W  = 112;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_PRESENT = 3'd6;

    // Leftmost pixel of a plane byte sits in the MSB.
    localparam logic [MASK_W-1:0] LEFT_PIXEL_BIT = 8'h80;
    localparam logic [2:0]        LAST_BIT_POS   = 3'd7;

    // One plane write as it leaves the block.
    typedef struct packed {
        logic                image_last;
        logic [EN_W-1:0]     plane_enables;
        logic [MASK_W-1:0]   bit_mask;
        logic [BYTES_W-1:0]  plane_bytes;
        logic [OFFSET_W-1:0] byte_offset;
    } c2p_result_t;

endpackage

// ===== rtl/core/chunky_to_planar_writer.sv =====
// Top level of the chunky-to-planar writer: pixel gathering, offset tracking and output skid.
//
// Usage:
//   Pixels enter on the s_ channel one per item, in row-major order over the
//   rectangle set by the configuration registers. Bit d of a pixel lands in
//   plane d, the leftmost pixel in the MSB of a plane byte. When a byte fills
//   up or a row ends, one plane write leaves on the m_ channel with its byte
//   offset, the new plane bytes, the mask of written pixels and the plane
//   enables; m_tlast marks the write that closes the rectangle.
//   Throughput is one pixel per cycle while s_tready is high. A finished write
//   goes to the output register, or to the skid register while a write waits;
//   all position and gather logic sits between the state and output registers.
//   A two-entry output buffer (output register plus skid register) lets the
//   block keep taking pixels while a write waits; s_tready drops only when
//   both entries are full, so a stalled receiver holds back the pixel stream.
//   Reset (aresetn low, synchronous) loads the register defaults, empties the
//   buffer and arms the rectangle. Any register write re-arms it as well.
//   With a zero width or height, pixels are taken and dropped.
module chunky_to_planar_writer #(
    parameter int unsigned MAX_PLANES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Pixel input; tdata: chunky_pixel[7:0].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [c2p_pkg::PIXEL_W-1:0]         s_tdata,
    // Plane writes; tdata: byte_offset[27:0], plane_bytes[91:28],
    // bit_mask[99:92], plane_enables[107:100], zero fill[111:108].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [c2p_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [c2p_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [c2p_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import c2p_pkg::*;

    localparam int unsigned GATHER_W = MAX_PLANES * 8;

    // Configuration registers.
    logic [BPR_W-1:0]   bytes_per_row_reg;
    logic [COORD_W-1:0] start_x_reg, start_y_reg, rect_width_reg, rect_height_reg;
    logic [DEPTH_W-1:0] plane_count_reg;
    logic [EN_W-1:0]    plane_present_reg;

    // Position and gather state.
    logic                rearm_reg, rearm_next;
    logic [COORD_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [2:0]          bitpos_reg, bitpos_next;
    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [OFFSET_W-1:0] cur_off_reg, cur_off_next, row_off_reg, row_off_next;

    // Output buffer.
    logic        out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    c2p_result_t out_reg, out_next, skid_reg, skid_next;

    // Step logic.
    logic                s_fire, rect_empty, rearm_now, row_end, emit, push;
    logic [OFFSET_W-1:0] base_off;
    logic [COORD_W-1:0]  e_col, e_row, col_inc, row_inc;
    logic [2:0]          e_bitpos;
    logic [GATHER_W-1:0] e_gather, new_gather;
    logic [MASK_W-1:0]   e_mask, new_mask, pos_bit;
    logic [OFFSET_W-1:0] e_cur_off, e_row_off, next_row_off;
    logic [DEPTH_W-1:0]  depth;
    logic [EN_W-1:0]     enables;
    logic [BYTES_W-1:0]  keep, gather_wide;
    c2p_result_t         result;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.image_last;
    assign m_tdata  = {{(M_TDATA_W - $bits(c2p_result_t) + 1){1'b0}},
                       out_reg.plane_enables, out_reg.bit_mask,
                       out_reg.plane_bytes, out_reg.byte_offset};

    // Rectangle base offset: start_y rows down plus the byte of start_x.
    assign base_off = OFFSET_W'(start_y_reg) * OFFSET_W'(bytes_per_row_reg)
                    + OFFSET_W'(start_x_reg[COORD_W-1:3]);

    // Configuration registers; every listed register write re-arms the rectangle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_per_row_reg <= BPR_W'(40);
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            plane_count_reg   <= DEPTH_W'(1);
            plane_present_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BYTES_PER_ROW: bytes_per_row_reg <= cfg_wdata[BPR_W-1:0];
                REG_START_X:       start_x_reg       <= cfg_wdata;
                REG_START_Y:       start_y_reg       <= cfg_wdata;
                REG_RECT_WIDTH:    rect_width_reg    <= cfg_wdata;
                REG_RECT_HEIGHT:   rect_height_reg   <= cfg_wdata;
                REG_PLANE_COUNT:   plane_count_reg   <= cfg_wdata[DEPTH_W-1:0];
                REG_PLANE_PRESENT: plane_present_reg <= cfg_wdata[EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Plane enables: present planes below the saturated depth.
    always_comb begin
        depth = (plane_count_reg > DEPTH_W'(MAX_PLANES)) ? DEPTH_W'(MAX_PLANES)
                                                         : plane_count_reg;
        for (int d = 0; d < EN_W; d++) begin
            enables[d] = plane_present_reg[d] && (DEPTH_W'(d) < depth);
        end
    end

    // Effective state: an armed rectangle reads as its start position.
    assign rect_empty = (rect_width_reg == '0) || (rect_height_reg == '0);
    assign rearm_now  = rearm_reg || (col_reg >= rect_width_reg)
                      || (row_reg >= rect_height_reg);
    assign e_col      = rearm_now ? '0 : col_reg;
    assign e_row      = rearm_now ? '0 : row_reg;
    assign e_bitpos   = rearm_now ? start_x_reg[2:0] : bitpos_reg;
    assign e_gather   = rearm_now ? '0 : gather_reg;
    assign e_mask     = rearm_now ? '0 : mask_reg;
    assign e_cur_off  = rearm_now ? base_off : cur_off_reg;
    assign e_row_off  = rearm_now ? base_off : row_off_reg;

    // Drop the pixel bits into their byte position in every plane.
    assign pos_bit = LEFT_PIXEL_BIT >> e_bitpos;
    always_comb begin
        for (int d = 0; d < MAX_PLANES; d++) begin
            new_gather[d*8 +: 8] = s_tdata[d] ? (e_gather[d*8 +: 8] | pos_bit)
                                              : (e_gather[d*8 +: 8] & ~pos_bit);
        end
    end
    assign new_mask     = e_mask | pos_bit;
    assign col_inc      = e_col + COORD_W'(1);
    assign row_inc      = e_row + COORD_W'(1);
    assign row_end      = (col_inc == rect_width_reg);
    assign emit         = (e_bitpos == LAST_BIT_POS) || row_end;
    assign next_row_off = e_row_off + OFFSET_W'(bytes_per_row_reg);
    assign push         = s_fire && !rect_empty && emit;

    // Assemble the plane write, keeping only written bits of enabled planes.
    always_comb begin
        gather_wide = BYTES_W'(new_gather);
        for (int d = 0; d < EN_W; d++) begin
            keep[d*8 +: 8] = enables[d] ? new_mask : '0;
        end
        result.byte_offset   = e_cur_off;
        result.plane_bytes   = gather_wide & keep;
        result.bit_mask      = new_mask;
        result.plane_enables = enables;
        result.image_last    = row_end && (row_inc >= rect_height_reg);
    end

    // Next position and gather state.
    always_comb begin
        rearm_next   = rearm_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        bitpos_next  = bitpos_reg;
        gather_next  = gather_reg;
        mask_next    = mask_reg;
        cur_off_next = cur_off_reg;
        row_off_next = row_off_reg;
        if (cfg_we && (cfg_index <= REG_PLANE_PRESENT)) begin
            rearm_next = 1'b1;
        end else if (s_fire && !rect_empty) begin
            rearm_next   = 1'b0;
            row_next     = e_row;
            row_off_next = e_row_off;
            if (!emit) begin
                col_next     = col_inc;
                bitpos_next  = e_bitpos + 3'd1;
                gather_next  = new_gather;
                mask_next    = new_mask;
                cur_off_next = e_cur_off;
            end else begin
                gather_next = '0;
                mask_next   = '0;
                if (row_end) begin
                    col_next     = '0;
                    row_next     = row_inc;
                    row_off_next = next_row_off;
                    cur_off_next = next_row_off;
                    bitpos_next  = start_x_reg[2:0];
                    rearm_next   = result.image_last;
                end else begin
                    col_next     = col_inc;
                    cur_off_next = e_cur_off + OFFSET_W'(1);
                    bitpos_next  = 3'd0;
                end
            end
        end
    end

    // Output register with a skid entry behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next  = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end else begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rearm_reg      <= 1'b1;
            col_reg        <= '0;
            row_reg        <= '0;
            bitpos_reg     <= '0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            rearm_reg      <= rearm_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bitpos_reg     <= bitpos_next;
            mask_reg       <= mask_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        gather_reg  <= gather_next;
        cur_off_reg <= cur_off_next;
        row_off_reg <= row_off_next;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    // The skid entry is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Every write carries at least one pixel.
    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.bit_mask != '0))
        else $error("plane write with empty bit mask");

    // The write that closes the rectangle re-arms it.
    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && result.image_last) |=> rearm_reg)
        else $error("rectangle not re-armed after its last write");

    // While running, the column counter stays inside the row.
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (!rearm_reg && !$past(cfg_we)) |-> (col_reg < rect_width_reg || rect_empty))
        else $error("column counter ran past the row");

    // A pending byte always has its mask bits below the current position.
    a_mask_follows_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (!rearm_reg && mask_reg != '0) |-> (mask_reg[0] == 1'b0))
        else $error("gathered mask holds a completed byte");

endmodule
